>>> rtl/lruc_pkg.sv
// lruc_pkg: shared constants for the lru cache lookup block
// used by lruc_store, lru_cache_lookup and the testbench; depends on nothing
`default_nettype none

package lruc_pkg;

  // capacity register width and its reset value
  localparam int CAP_WIDTH = 5;
  localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;

endpackage

`default_nettype wire

>>> rtl/lruc_match.sv
// lruc_match: parallel key compare against every stored entry
// purely combinational; depends on nothing
`default_nettype none

module lruc_match #(
  parameter int ENTRIES   = 16,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic [KEY_WIDTH-1:0] key,
  input  wire logic [KEY_WIDTH-1:0] stored_keys [ENTRIES],
  input  wire logic [ENTRIES-1:0]   entry_valid,
  output logic      [ENTRIES-1:0]   match_vec,
  output logic                      hit
);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = entry_valid[i] && (stored_keys[i] == key);
    end
    hit = |match_vec;
  end

endmodule

`default_nettype wire

>>> rtl/lruc_store.sv
// lruc_store: key store, valid bits, recency ranks and occupancy with lru update
// depends on lruc_pkg and lruc_match
`default_nettype none

module lruc_store #(
  parameter int ENTRIES   = 16,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           upd_en,
  input  wire logic [KEY_WIDTH-1:0]           key,
  input  wire logic [lruc_pkg::CAP_WIDTH-1:0] capacity,
  output logic                                hit
);

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = ((OCC_W > lruc_pkg::CAP_WIDTH) ? OCC_W : lruc_pkg::CAP_WIDTH) + 1;
  localparam logic [CMP_W-1:0] ENTRIES_C = CMP_W'(ENTRIES);

  logic [KEY_WIDTH-1:0] stored_keys [ENTRIES];
  logic [ENTRIES-1:0]   entry_valid;
  logic [RANK_W-1:0]    recency_rank [ENTRIES];
  logic [OCC_W-1:0]     occupancy;

  logic [ENTRIES-1:0]   match_vec;
  logic [ENTRIES-1:0]   free_vec;
  logic [ENTRIES-1:0]   first_free;
  logic [ENTRIES-1:0]   victim_vec;
  logic [ENTRIES-1:0]   target;
  logic [RANK_W-1:0]    hit_rank;
  logic [RANK_W-1:0]    oldest_rank;
  logic [RANK_W-1:0]    thr;
  logic [CMP_W-1:0]     cap_ext;
  logic [CMP_W-1:0]     eff_cap;
  logic                 fill;
  logic                 age_all;

  lruc_match #(
    .ENTRIES  (ENTRIES),
    .KEY_WIDTH(KEY_WIDTH)
  ) u_match (
    .key        (key),
    .stored_keys(stored_keys),
    .entry_valid(entry_valid),
    .match_vec  (match_vec),
    .hit        (hit)
  );

  always_comb begin
    // clamp capacity to 1..ENTRIES
    cap_ext = CMP_W'(capacity);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > ENTRIES_C) begin
      eff_cap = ENTRIES_C;
    end else begin
      eff_cap = cap_ext;
    end
    fill = !hit && (CMP_W'(occupancy) < eff_cap);

    // lowest free slot
    free_vec   = ~entry_valid;
    first_free = free_vec & (~free_vec + ENTRIES'(1));

    // ranks of valid entries are distinct 0..occupancy-1, so the oldest holds occupancy-1
    oldest_rank = RANK_W'(occupancy - OCC_W'(1));
    hit_rank    = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      victim_vec[i] = entry_valid[i] && (recency_rank[i] == oldest_rank);
      if (match_vec[i]) begin
        hit_rank = hit_rank | recency_rank[i];
      end
    end

    if (hit) begin
      target  = match_vec;
      thr     = hit_rank;
      age_all = 1'b0;
    end else if (fill) begin
      target  = first_free;
      thr     = '0;
      age_all = 1'b1;
    end else begin
      target  = victim_vec;
      thr     = oldest_rank;
      age_all = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      occupancy   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        recency_rank[i] <= '0;
      end
    end else if (upd_en) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (target[i]) begin
          recency_rank[i] <= '0;
          entry_valid[i]  <= 1'b1;
        end else if (entry_valid[i] && (age_all || recency_rank[i] < thr)) begin
          recency_rank[i] <= recency_rank[i] + RANK_W'(1);
        end
      end
      if (fill) begin
        occupancy <= occupancy + OCC_W'(1);
      end
    end
  end

  // key payload, no reset
  always_ff @(posedge clk) begin
    if (upd_en && !hit) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (target[i]) begin
          stored_keys[i] <= key;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/lru_cache_lookup.sv
// lru_cache_lookup: fully associative lru cache of page keys, top level
// depends on lruc_pkg and lruc_store
//
// usage:
//   requests enter on in_valid / in_stall with page_key; a request is taken at a
//   rising edge with in_valid high and in_stall low. each request yields one
//   result on out_valid / out_stall carrying hit (1 = key was cached).
//   a taken request sits in the input register, where all stored keys are
//   compared at once; as it moves on, the lru state is updated and the result
//   lands in the output register, which raises out_valid. throughput is one
//   request per cycle while out_stall does not hold the output. capacity is
//   written through cfg_wr_en / cfg_wr_data; the user must do this only while
//   no request is in flight, the block does not enforce it. values of zero act
//   as one, values above ENTRIES act as ENTRIES. reset empties the store and
//   sets capacity to 16. when out_stall holds the output, the input register
//   keeps its request and in_stall rises while it is full; a request in flight
//   is never dropped.
`default_nettype none

module lru_cache_lookup #(
  parameter int ENTRIES   = 16,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic [lruc_pkg::CAP_WIDTH-1:0] cfg_wr_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [KEY_WIDTH-1:0]    page_key,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                hit
);

  logic [lruc_pkg::CAP_WIDTH-1:0] capacity;
  logic                           s1_valid;
  logic [KEY_WIDTH-1:0]           s1_key;
  logic                           s1_go;
  logic                           lookup_hit;

  // stage 1 moves on when the output register is empty or being drained
  assign s1_go    = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lruc_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!s1_valid || s1_go) begin
        s1_valid <= in_valid;
      end
      if (s1_go) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && (!s1_valid || s1_go)) begin
      s1_key <= KEY_WIDTH'(unsigned'(page_key));
    end
    if (s1_go && s1_valid) begin
      hit <= lookup_hit;
    end
  end

  lruc_store #(
    .ENTRIES  (ENTRIES),
    .KEY_WIDTH(KEY_WIDTH)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .upd_en  (s1_valid && s1_go),
    .key     (s1_key),
    .capacity(capacity),
    .hit     (lookup_hit)
  );

endmodule

`default_nettype wire

>>> test/tb_lru_cache_lookup.sv
// tb_lru_cache_lookup: self-checking testbench for the lru cache lookup block
// keeps its own lru model of the key store and checks every hit flag in order
// depends on lruc_pkg and lru_cache_lookup
`default_nettype none

module tb_lru_cache_lookup;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = 16;
  localparam int KEY_WIDTH = 32;
  localparam int POOL_SIZE = 40;
  localparam int HOLD_CYCLES = 300;

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PATTERN, RX_HOLD} rx_mode_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_wr_en = 1'b0;
  logic [lruc_pkg::CAP_WIDTH-1:0]  cfg_wr_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic signed [KEY_WIDTH-1:0]     page_key = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic                            hit;

  // model of the key store
  logic [KEY_WIDTH-1:0]            page_tag [ENTRIES];
  logic                            tag_valid [ENTRIES];
  logic [3:0]                      age_rank [ENTRIES];
  logic [4:0]                      fill_count;
  logic [lruc_pkg::CAP_WIDTH-1:0]  cache_capacity;

  bit                              hit_expect_q [$];
  bit                              hit_expected;
  int                              error_count = 0;
  rx_mode_t                        rx_mode = RX_FREE;
  int                              tx_gap_max = 0;
  int                              burst_left = 0;
  logic [KEY_WIDTH-1:0]            key_pool [POOL_SIZE];

  lru_cache_lookup #(
    .ENTRIES   (ENTRIES),
    .KEY_WIDTH (KEY_WIDTH)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .page_key    (page_key),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // entry idx becomes newest; entries newer than old_rank age by one
  function automatic void age_entries(input int idx, input int old_rank);
    int i;
    for (i = 0; i < ENTRIES; i++)
      if (tag_valid[i] && age_rank[i] < old_rank) age_rank[i]++;
    age_rank[idx] = 4'd0;
  endfunction

  function automatic int active_entries();
    if (cache_capacity < 1) return 1;
    if (cache_capacity > ENTRIES) return ENTRIES;
    return int'(cache_capacity);
  endfunction

  // looks the key up, updates the model and returns the hit flag
  function automatic bit lookup_page(input logic [KEY_WIDTH-1:0] key);
    int i;
    int found;
    int slot;
    int victim;
    int worst;
    found = -1;
    slot = -1;
    victim = -1;
    worst = 0;
    for (i = 0; i < ENTRIES; i++)
      if (tag_valid[i] && page_tag[i] == key) found = i;
    if (found >= 0) begin
      age_entries(found, age_rank[found]);
      return 1'b1;
    end
    if (fill_count < active_entries()) begin
      for (i = ENTRIES - 1; i >= 0; i--)
        if (!tag_valid[i]) slot = i;
      if (slot >= 0) begin
        age_entries(slot, ENTRIES);
        tag_valid[slot] = 1'b1;
        page_tag[slot] = key;
        fill_count++;
      end
    end else begin
      // evict the oldest valid entry, even past a lowered capacity
      for (i = 0; i < ENTRIES; i++) begin
        if (tag_valid[i] && (victim < 0 || age_rank[i] > worst)) begin
          victim = i;
          worst = age_rank[i];
        end
      end
      if (victim >= 0) begin
        page_tag[victim] = key;
        age_entries(victim, worst);
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [KEY_WIDTH-1:0] pick_key(input int span);
    if ($urandom_range(0, 4) == 0) return $urandom();
    return key_pool[$urandom_range(0, span - 1)];
  endfunction

  // one request, paced in bursts; predicts at the accepting edge
  task automatic send_page(input logic [KEY_WIDTH-1:0] key);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    page_key <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hit_expect_q.push_back(lookup_page(key));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (hit_expect_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [lruc_pkg::CAP_WIDTH-1:0] value);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cache_capacity = value;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [lruc_pkg::CAP_WIDTH-1:0] cap, input int gap_max,
                           input rx_mode_t mode, input int count);
    int span;
    int n;
    set_capacity(cap);
    tx_gap_max = gap_max;
    rx_mode = mode;
    span = active_entries() + 6;
    for (n = 0; n < count; n++) send_page(pick_key(span));
  endtask

  task automatic test_key_extremes();
    tx_gap_max = 0;
    rx_mode = RX_FREE;
    send_page(32'h0000_0000);
    send_page(32'h8000_0000);
    send_page(32'h7fff_ffff);
    send_page(32'hffff_ffff);
    send_page(32'h0000_0001);
    send_page(32'h8000_0000);
    send_page(32'hffff_ffff);
    send_page(32'h0000_0000);
  endtask

  // capacity below the current fill: misses replace the oldest entry
  task automatic test_lru_eviction();
    set_capacity(5'd3);
    send_page(32'h0000_0010);
    send_page(32'h0000_0011);
    send_page(32'h0000_0012);
    send_page(32'h0000_0010);
    send_page(32'h0000_0013);
    send_page(32'h0000_0011);
    send_page(32'h0000_0010);
  endtask

  task automatic test_capacity_edges();
    set_capacity(5'd1);
    send_page(32'h0000_0020);
    send_page(32'h0000_0020);
    send_page(32'h0000_0021);
    send_page(32'h0000_0020);
    set_capacity(5'd0);
    send_page(32'h0000_0022);
    send_page(32'h0000_0022);
    set_capacity(5'd31);
    send_page(32'h0000_0023);
    send_page(32'h0000_0024);
  endtask

  task automatic test_random_traffic();
    run_phase(5'd16, 0, RX_FREE, 110);
    run_phase(5'd1, 6, RX_RANDOM, 110);
    run_phase(5'd0, 3, RX_PATTERN, 110);
    run_phase(5'd31, 8, RX_RANDOM, 110);
    run_phase(5'd5, 2, RX_PATTERN, 110);
    run_phase(5'($urandom_range(2, 15)), 4, RX_RANDOM, 110);
    run_phase(5'd17, 5, RX_RANDOM, 110);
    run_phase(5'd16, 3, RX_PATTERN, 110);
  endtask

  // receiver holds off while requests keep coming, so the block backs up
  task automatic test_backpressure();
    int n;
    set_capacity(5'd8);
    tx_gap_max = 0;
    rx_mode = RX_HOLD;
    for (n = 0; n < 40; n++) send_page(pick_key(14));
    rx_mode = RX_RANDOM;
  endtask

  task automatic test_drain_pause();
    int n;
    tx_gap_max = 3;
    rx_mode = RX_RANDOM;
    for (n = 0; n < 30; n++) send_page(pick_key(14));
    wait_idle();
    for (n = 0; n < 30; n++) send_page(pick_key(14));
  endtask

  initial begin : receiver
    int hold_count;
    int beat;
    hold_count = 0;
    beat = 0;
    forever begin
      @(posedge clk);
      beat++;
      case (rx_mode)
        RX_FREE:    out_stall <= 1'b0;
        RX_RANDOM:  out_stall <= ($urandom_range(0, 3) == 0);
        RX_PATTERN: out_stall <= ((beat % 9) < 3);
        RX_HOLD:    out_stall <= (hold_count < HOLD_CYCLES);
        default:    out_stall <= 1'b0;
      endcase
      hold_count = (rx_mode == RX_HOLD) ? hold_count + 1 : 0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (hit_expect_q.size() == 0) begin
        $display("%0t: result with no request pending, expected none actual hit=%0b",
                 $time, hit);
        error_count++;
      end else begin
        hit_expected = hit_expect_q.pop_front();
        if (hit !== hit_expected) begin
          $display("%0t: hit mismatch, expected %0b actual %0b", $time, hit_expected, hit);
          error_count++;
        end
      end
    end
  end

  initial begin : main
    int i;
    int waited;
    for (i = 0; i < ENTRIES; i++) begin
      page_tag[i] = '0;
      tag_valid[i] = 1'b0;
      age_rank[i] = 4'd0;
    end
    fill_count = '0;
    cache_capacity = lruc_pkg::CAP_RESET;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'h8000_0000;
    key_pool[2] = 32'h0000_0001;
    key_pool[3] = 32'hffff_ffff;
    for (i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom();

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_key_extremes();
    test_lru_eviction();
    test_capacity_edges();
    test_random_traffic();
    test_backpressure();
    test_drain_pause();

    in_valid <= 1'b0;
    waited = 0;
    while (hit_expect_q.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (hit_expect_q.size() != 0) begin
      $display("%0t: %0d requests never answered, expected results actual none",
               $time, hit_expect_q.size());
      error_count++;
    end
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
